// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mbd_pkg.sv
package mbd_pkg;

  localparam int unsigned VOLT_W     = 33;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [7:0]  PWM_FULL   = 8'd255;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    LAW_BDOT  = 2'd0,
    LAW_POINT = 2'd1,
    LAW_OFF   = 2'd2
  } law_e;

  typedef enum logic [2:0] {
    REG_K_BDOT   = 3'd0,
    REG_K_OMEGA  = 3'd1,
    REG_K_ALPHA  = 3'd2,
    REG_DET_STOP = 3'd3,
    REG_PT_STOP  = 3'd4,
    REG_TARGET   = 3'd5,
    REG_MAX_VOLT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] rate;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic [15:0]        heading;
  } in_t;

  typedef struct packed {
    logic       dir_x;
    logic [7:0] pwm_x;
    logic       dir_y;
    logic [7:0] pwm_y;
    logic [1:0] law_used;
  } out_t;

  typedef struct packed {
    logic [15:0] k_bdot;
    logic [15:0] k_omega;
    logic [15:0] k_alpha;
    logic [14:0] det_stop;
    logic [14:0] pt_stop;
    logic [15:0] target;
    logic [15:0] vmax;
  } cfg_t;

  typedef struct packed {
    law_e                     law;
    logic signed [VOLT_W-1:0] vx;
    logic signed [VOLT_W-1:0] vy;
  } volt_t;

  typedef struct packed {
    law_e        law;
    logic        neg;
    logic        scale;
    logic [15:0] mag;
  } scl_t;

  typedef struct packed {
    law_e law;
    logic neg;
  } pwm_side_t;

  // quarter-wave sine entry, Q0.15, from a Q30 angle by truncated taylor series
  function automatic logic [14:0] sine_entry(input longint unsigned x);
    longint unsigned t;
    longint          sum;
    longint unsigned v;
    t   = x;
    sum = longint'(x);
    t   = ((t * x) >> 30) / 6;
    sum = sum - longint'(t);
    t   = ((t * x) >> 30) / 20;
    sum = sum + longint'(t);
    t   = ((t * x) >> 30) / 42;
    sum = sum - longint'(t);
    t   = ((t * x) >> 30) / 72;
    sum = sum + longint'(t);
    t   = ((t * x) >> 30) / 110;
    sum = sum - longint'(t);
    t   = ((t * x) >> 30) / 156;
    sum = sum + longint'(t);
    t   = ((t * x) >> 30) / 210;
    sum = sum - longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

// File: hdl/mbd_stream_if.sv
interface mbd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/mbd_law.sv
module mbd_law #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  mbd_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  mbd_pkg::in_t    data_i,
  output logic            valid_o,
  output mbd_pkg::volt_t  volt_o
);

  localparam int unsigned IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned ProdW = 15 + IdxW;
  localparam int unsigned VW    = mbd_pkg::VOLT_W;

  // sine table
  logic [14:0] sine_tab [SINE_TABLE_DEPTH+1];
  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_sine
    localparam longint unsigned X = (mbd_pkg::HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
    assign sine_tab[i] = mbd_pkg::sine_entry(X);
  end

  // stage 1: law select, table index
  logic [15:0]      rate_abs;
  logic [15:0]      ang;
  logic [14:0]      ofs;
  logic [ProdW-1:0] idx_prod;
  mbd_pkg::law_e    law1_d;

  always_comb begin
    rate_abs = data_i.rate[15] ? (~data_i.rate + 16'sd1) : data_i.rate;
    ang      = cfg_i.target - data_i.heading;
    ofs      = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    idx_prod = ProdW'(ofs) * ProdW'(SINE_TABLE_DEPTH);
    if (!data_i.req_type) begin
      law1_d = (rate_abs >= {1'b0, cfg_i.det_stop}) ? mbd_pkg::LAW_BDOT : mbd_pkg::LAW_OFF;
    end else begin
      law1_d = (rate_abs >= {1'b0, cfg_i.pt_stop}) ? mbd_pkg::LAW_BDOT : mbd_pkg::LAW_POINT;
    end
  end

  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  mbd_pkg::law_e      law1_q, law2_q, law3_q, law4_q, law5_q;
  logic               neg1_q;
  logic [IdxW-1:0]    idx1_q;
  logic signed [15:0] rate1_q;
  logic signed [15:0] bx1_q, bx2_q, bx3_q, bx4_q;
  logic signed [15:0] by1_q, by2_q, by3_q, by4_q;

  // stage 2: sine lookup, rate gain product
  logic [14:0]          sine_mag;
  logic signed [15:0]   s2_d;
  logic [15:0]          kg;
  logic signed [VW-1:0] g2_d;
  logic signed [15:0]   s2_q;
  logic signed [VW-1:0] g2_q, g3_q;

  always_comb begin
    sine_mag = sine_tab[idx1_q];
    s2_d     = neg1_q ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
    case (law1_q)
      mbd_pkg::LAW_BDOT:  kg = cfg_i.k_bdot;
      mbd_pkg::LAW_POINT: kg = cfg_i.k_omega;
      default:            kg = 16'd0;
    endcase
    g2_d = VW'($signed({1'b0, kg})) * VW'(rate1_q);
  end

  // stage 3: angle gain product
  logic signed [VW-1:0] ka3_d, ka3_q;
  assign ka3_d = VW'($signed({1'b0, cfg_i.k_alpha})) * VW'(s2_q);

  // stage 4: combined gain
  logic signed [VW-1:0] c4_d, c4_q;
  assign c4_d = (law3_q == mbd_pkg::LAW_POINT) ? (g3_q - (ka3_q >>> 7)) : g3_q;

  // stage 5: field products, floor shift by 16
  logic signed [16:0]   nby;
  logic signed [49:0]   px, py;
  logic signed [VW-1:0] vx5_q, vy5_q;

  always_comb begin
    nby = -{by4_q[15], by4_q};
    px  = 50'(c4_q) * 50'(nby);
    py  = 50'(c4_q) * 50'(bx4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      law1_q  <= law1_d;
      neg1_q  <= ang[15];
      idx1_q  <= idx_prod[14 +: IdxW];
      rate1_q <= data_i.rate;
      bx1_q   <= data_i.field_x;
      by1_q   <= data_i.field_y;

      law2_q  <= law1_q;
      s2_q    <= s2_d;
      g2_q    <= g2_d;
      bx2_q   <= bx1_q;
      by2_q   <= by1_q;

      law3_q  <= law2_q;
      ka3_q   <= ka3_d;
      g3_q    <= g2_q;
      bx3_q   <= bx2_q;
      by3_q   <= by2_q;

      law4_q  <= law3_q;
      c4_q    <= c4_d;
      bx4_q   <= bx3_q;
      by4_q   <= by3_q;

      law5_q  <= law4_q;
      vx5_q   <= px[48:16];
      vy5_q   <= py[48:16];
    end
  end

  assign valid_o    = v5_q;
  assign volt_o.law = law5_q;
  assign volt_o.vx  = vx5_q;
  assign volt_o.vy  = vy5_q;

endmodule

// File: hdl/mbd_div.sv
module mbd_div #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // one quotient bit per stage, restoring
  logic              valid_q [QUO_W];
  logic [DEN_W-1:0]  rem_q   [QUO_W];
  logic [DEN_W-1:0]  den_q   [QUO_W];
  logic [QUO_W-1:0]  bits_q  [QUO_W];
  logic [SIDE_W-1:0] side_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic              valid_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  bits_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign den_in   = den_i;
      assign bits_in  = num_i[QUO_W-1:0];
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign bits_in  = bits_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = {rem_in, bits_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[k]  <= den_in;
        bits_q[k] <= (bits_in << 1) | QUO_W'(take);
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = bits_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// File: hdl/magnetorquer_bdot_pwm_drive.sv
// channel   dir   payload         transaction when
// in_ch     in    mbd_pkg::in_t   valid && ready
// out_ch    out   mbd_pkg::out_t  valid && ready
// cfg       in    idx / wdata     cfg_we_i high
//
// one transaction per cycle sustained while the output is not stalled
// the path to the output register runs through the 16-stage scaling divider and the 8-stage duty divider
// reset clears valid bits and loads register defaults, no clearing pass
// a stalled output fills one skid entry, then the whole pipeline holds and in_ch.ready drops
`include "assert_macros.svh"

module magnetorquer_bdot_pwm_drive #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mbd_stream_if.sink                       in_ch,
  mbd_stream_if.source                     out_ch
);

  // configuration
  mbd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_bdot   <= 16'd0;
      cfg_q.k_omega  <= 16'd0;
      cfg_q.k_alpha  <= 16'd0;
      cfg_q.det_stop <= 15'd0;
      cfg_q.pt_stop  <= 15'd0;
      cfg_q.target   <= 16'd0;
      cfg_q.vmax     <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbd_pkg::REG_K_BDOT:   cfg_q.k_bdot   <= cfg_wdata_i;
        mbd_pkg::REG_K_OMEGA:  cfg_q.k_omega  <= cfg_wdata_i;
        mbd_pkg::REG_K_ALPHA:  cfg_q.k_alpha  <= cfg_wdata_i;
        mbd_pkg::REG_DET_STOP: cfg_q.det_stop <= cfg_wdata_i[14:0];
        mbd_pkg::REG_PT_STOP:  cfg_q.pt_stop  <= cfg_wdata_i[14:0];
        mbd_pkg::REG_TARGET:   cfg_q.target   <= cfg_wdata_i;
        mbd_pkg::REG_MAX_VOLT: cfg_q.vmax     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [15:0] vmax_eff;
  assign vmax_eff = (cfg_q.vmax == 16'd0) ? 16'd1 : cfg_q.vmax;

  // pipeline advance
  logic skid_valid_q;
  logic en;
  assign en          = !skid_valid_q;
  assign in_ch.ready = en;

  // control law
  logic           volt_valid;
  mbd_pkg::volt_t volt;

  mbd_law #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_law (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_ch.valid),
    .data_i  (in_ch.data),
    .valid_o (volt_valid),
    .volt_o  (volt)
  );

  // magnitudes and scaling decision
  logic signed [32:0] nvx, nvy;
  logic [31:0]        ax_d, ay_d, m_d;

  always_comb begin
    nvx  = -volt.vx;
    nvy  = -volt.vy;
    ax_d = volt.vx[32] ? nvx[31:0] : volt.vx[31:0];
    ay_d = volt.vy[32] ? nvy[31:0] : volt.vy[31:0];
    m_d  = (ax_d >= ay_d) ? ax_d : ay_d;
  end

  logic          v1_q, v2_q, v3_q;
  mbd_pkg::law_e law1_q;
  logic          sx1_q, sy1_q, scale1_q;
  logic [31:0]   ax1_q, ay1_q, m1_q, m2_q;
  logic [47:0]   nx2_q, ny2_q;
  mbd_pkg::scl_t sclx2_q, scly2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= volt_valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      law1_q         <= volt.law;
      sx1_q          <= volt.vx[32];
      sy1_q          <= volt.vy[32];
      scale1_q       <= m_d >= {16'd0, vmax_eff};
      ax1_q          <= ax_d;
      ay1_q          <= ay_d;
      m1_q           <= m_d;

      nx2_q          <= 48'(ax1_q) * 48'(vmax_eff);
      ny2_q          <= 48'(ay1_q) * 48'(vmax_eff);
      m2_q           <= m1_q;
      sclx2_q.law    <= law1_q;
      sclx2_q.neg    <= sx1_q;
      sclx2_q.scale  <= scale1_q;
      sclx2_q.mag    <= ax1_q[15:0];
      scly2_q.law    <= law1_q;
      scly2_q.neg    <= sy1_q;
      scly2_q.scale  <= scale1_q;
      scly2_q.mag    <= ay1_q[15:0];
    end
  end

  // common scaling to the voltage limit
  logic          sdx_valid, sdy_valid;
  logic [15:0]   sdx_quo, sdy_quo;
  mbd_pkg::scl_t sdx_side, sdy_side;

  mbd_div #(
    .NUM_W(48), .DEN_W(32), .QUO_W(16), .SIDE_W($bits(mbd_pkg::scl_t))
  ) u_scale_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v2_q),
    .num_i(nx2_q), .den_i(m2_q), .side_i(sclx2_q),
    .valid_o(sdx_valid), .quo_o(sdx_quo), .side_o(sdx_side)
  );

  mbd_div #(
    .NUM_W(48), .DEN_W(32), .QUO_W(16), .SIDE_W($bits(mbd_pkg::scl_t))
  ) u_scale_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v2_q),
    .num_i(ny2_q), .den_i(m2_q), .side_i(scly2_q),
    .valid_o(sdy_valid), .quo_o(sdy_quo), .side_o(sdy_side)
  );

  // duty numerator: 510 * v + vmax, over 2 * vmax
  logic [15:0]        ax_s, ay_s;
  logic [24:0]        numx3_d, numy3_d;
  logic [24:0]        numx3_q, numy3_q;
  mbd_pkg::pwm_side_t pwx3_q, pwy3_q;

  always_comb begin
    ax_s    = sdx_side.scale ? sdx_quo : sdx_side.mag;
    ay_s    = sdy_side.scale ? sdy_quo : sdy_side.mag;
    numx3_d = 25'({ax_s, 9'd0}) - 25'({ax_s, 1'b0}) + 25'(vmax_eff);
    numy3_d = 25'({ay_s, 9'd0}) - 25'({ay_s, 1'b0}) + 25'(vmax_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= sdx_valid && sdy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx3_q    <= numx3_d;
      numy3_q    <= numy3_d;
      pwx3_q.law <= sdx_side.law;
      pwx3_q.neg <= sdx_side.neg;
      pwy3_q.law <= sdy_side.law;
      pwy3_q.neg <= sdy_side.neg;
    end
  end

  logic               pdx_valid, pdy_valid;
  logic [7:0]         magx, magy;
  mbd_pkg::pwm_side_t pdx_side, pdy_side;

  mbd_div #(
    .NUM_W(25), .DEN_W(17), .QUO_W(8), .SIDE_W($bits(mbd_pkg::pwm_side_t))
  ) u_duty_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v3_q),
    .num_i(numx3_q), .den_i({vmax_eff, 1'b0}), .side_i(pwx3_q),
    .valid_o(pdx_valid), .quo_o(magx), .side_o(pdx_side)
  );

  mbd_div #(
    .NUM_W(25), .DEN_W(17), .QUO_W(8), .SIDE_W($bits(mbd_pkg::pwm_side_t))
  ) u_duty_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v3_q),
    .num_i(numy3_q), .den_i({vmax_eff, 1'b0}), .side_i(pwy3_q),
    .valid_o(pdy_valid), .quo_o(magy), .side_o(pdy_side)
  );

  // direction and complemented duty
  logic          res_valid;
  mbd_pkg::out_t res_data;
  logic          dirx, diry;

  always_comb begin
    res_valid         = pdx_valid && pdy_valid;
    dirx              = pdx_side.neg && (magx != 8'd0);
    diry              = pdy_side.neg && (magy != 8'd0);
    res_data.dir_x    = dirx;
    res_data.pwm_x    = dirx ? (mbd_pkg::PWM_FULL - magx) : magx;
    res_data.dir_y    = diry;
    res_data.pwm_y    = diry ? (mbd_pkg::PWM_FULL - magy) : magy;
    res_data.law_used = 2'(pdx_side.law);
  end

  // output register with skid entry
  logic          out_valid_q;
  mbd_pkg::out_t out_data_q, skid_data_q;
  logic          out_free;

  assign out_free = out_ch.ready || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_data;
    end else if (!skid_valid_q) begin
      skid_data_q <= res_data;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without output entry")
  `ASSERT_NEXT(a_skid_catch, (!out_free && res_valid && !skid_valid_q), skid_valid_q, "stalled transaction not caught")
  `ASSERT_IMPL(a_off_zero, (out_valid_q && out_data_q.law_used == mbd_pkg::LAW_OFF), (out_data_q.pwm_x == 8'd0 && out_data_q.pwm_y == 8'd0 && !out_data_q.dir_x && !out_data_q.dir_y), "coils off with nonzero drive")
  `ASSERT_IMPL(a_dir_duty, (out_valid_q && out_data_q.dir_x), (out_data_q.pwm_x != mbd_pkg::PWM_FULL), "negative direction with zero magnitude")

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SINE_DEPTH    = 256;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [mbd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mbd_stream_if #(.data_t(mbd_pkg::in_t)) in_ch ();
  mbd_stream_if #(.data_t(mbd_pkg::out_t)) out_ch ();

  magnetorquer_bdot_pwm_drive #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #1 clk_i = ~clk_i;

  longint unsigned sine_lut[0:SINE_DEPTH];
  mbd_pkg::cfg_t drive_cfg;
  mbd_pkg::in_t sample_queue[$];
  mbd_pkg::out_t duty_queue[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit pause_sender = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  function automatic void build_sine_lut();
    longint unsigned x;
    longint unsigned t;
    longint sum;
    longint unsigned v;
    for (int unsigned i = 0; i <= SINE_DEPTH; i++) begin
      x = (mbd_pkg::HALF_PI_Q30 * i) / SINE_DEPTH;
      t = x;
      sum = longint'(x);
      for (int unsigned k = 1; k <= 7; k++) begin
        t = ((t * x) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((longint'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
      sine_lut[i] = (v > 32767) ? 32767 : v;
    end
  endfunction

  function automatic void duty_of(input longint v, input longint unsigned vmax,
                                  output logic dir, output logic [7:0] duty);
    longint unsigned a;
    longint unsigned mag;
    a = (v < 0) ? longint'(-v) : longint'(v);
    mag = (a > vmax) ? 255 : (a * 510 + vmax) / (2 * vmax);
    if (v < 0 && mag > 0) begin
      dir = 1'b1;
      duty = mbd_pkg::PWM_FULL - mag[7:0];
    end else begin
      dir = 1'b0;
      duty = mag[7:0];
    end
  endfunction

  function automatic mbd_pkg::out_t coil_drive(input mbd_pkg::in_t it);
    longint w;
    longint bx;
    longint by;
    longint c;
    longint s;
    longint vx;
    longint vy;
    longint unsigned aw;
    longint unsigned vmax;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned m;
    longint unsigned p;
    longint unsigned idx;
    logic [15:0] err_ang;
    mbd_pkg::law_e law;
    mbd_pkg::out_t r;
    vmax = (drive_cfg.vmax == 0) ? 1 : drive_cfg.vmax;
    w = it.rate;
    bx = it.field_x;
    by = it.field_y;
    aw = (w < 0) ? -w : w;
    if (!it.req_type) begin
      if (aw >= drive_cfg.det_stop) begin
        c = longint'({48'd0, drive_cfg.k_bdot}) * w;
        law = mbd_pkg::LAW_BDOT;
      end else begin
        c = 0;
        law = mbd_pkg::LAW_OFF;
      end
    end else if (aw >= drive_cfg.pt_stop) begin
      c = longint'({48'd0, drive_cfg.k_bdot}) * w;
      law = mbd_pkg::LAW_BDOT;
    end else begin
      err_ang = drive_cfg.target - it.heading;
      p = 64'(err_ang[13:0]);
      if (err_ang[14]) begin
        p = 16384 - p;
      end
      idx = (p * SINE_DEPTH) >> 14;
      if (idx > SINE_DEPTH) begin
        idx = SINE_DEPTH;
      end
      s = longint'(sine_lut[idx]);
      if (err_ang[15]) begin
        s = -s;
      end
      c = longint'({48'd0, drive_cfg.k_omega}) * w
        - ((longint'({48'd0, drive_cfg.k_alpha}) * s) >>> 7);
      law = mbd_pkg::LAW_POINT;
    end
    vx = (c * (-by)) >>> 16;
    vy = (c * bx) >>> 16;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    m = (ax >= ay) ? ax : ay;
    if (m >= vmax) begin
      ax = (ax * vmax) / m;
      ay = (ay * vmax) / m;
      vx = (vx < 0) ? -longint'(ax) : longint'(ax);
      vy = (vy < 0) ? -longint'(ay) : longint'(ay);
    end
    duty_of(vx, vmax, r.dir_x, r.pwm_x);
    duty_of(vy, vmax, r.dir_y, r.pwm_y);
    r.law_used = law;
    return r;
  endfunction

  task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      mbd_pkg::REG_K_BDOT:   drive_cfg.k_bdot = val;
      mbd_pkg::REG_K_OMEGA:  drive_cfg.k_omega = val;
      mbd_pkg::REG_K_ALPHA:  drive_cfg.k_alpha = val;
      mbd_pkg::REG_DET_STOP: drive_cfg.det_stop = val[14:0];
      mbd_pkg::REG_PT_STOP:  drive_cfg.pt_stop = val[14:0];
      mbd_pkg::REG_TARGET:   drive_cfg.target = val;
      mbd_pkg::REG_MAX_VOLT: drive_cfg.vmax = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] kb, input logic [15:0] ko,
                           input logic [15:0] ka, input logic [15:0] det,
                           input logic [15:0] pt, input logic [15:0] tgt,
                           input logic [15:0] vm);
    write_reg(mbd_pkg::REG_K_BDOT, kb);
    write_reg(mbd_pkg::REG_K_OMEGA, ko);
    write_reg(mbd_pkg::REG_K_ALPHA, ka);
    write_reg(mbd_pkg::REG_DET_STOP, det);
    write_reg(mbd_pkg::REG_PT_STOP, pt);
    write_reg(mbd_pkg::REG_TARGET, tgt);
    write_reg(mbd_pkg::REG_MAX_VOLT, vm);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_ch.valid || duty_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_sample(input logic mode, input int rate, input int fx,
                                      input int fy, input int hd);
    mbd_pkg::in_t it;
    it.req_type = mode;
    it.rate = rate[15:0];
    it.field_x = fx[15:0];
    it.field_y = fy[15:0];
    it.heading = hd[15:0];
    sample_queue.push_back(it);
  endfunction

  function automatic int pick_field();
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 128)) - 64;
      1: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic void push_random();
    logic mode;
    int thr;
    int r;
    int hd;
    mode = 1'($urandom_range(0, 1));
    thr = mode ? int'(drive_cfg.pt_stop) : int'(drive_cfg.det_stop);
    case ($urandom_range(0, 3))
      0, 1: r = int'($urandom_range(0, 65535)) - 32768;
      2: begin
        r = thr + int'($urandom_range(0, 8)) - 4;
        if (r < 0) begin
          r = 0;
        end
        if ($urandom_range(0, 1) != 0) begin
          r = -r;
        end
      end
      default: r = int'($urandom_range(0, 512)) - 256;
    endcase
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    if ($urandom_range(0, 3) == 0) begin
      hd = int'(drive_cfg.target) + int'($urandom_range(0, 64)) - 32;
    end else begin
      hd = int'($urandom_range(0, 65535));
    end
    push_sample(mode, r, pick_field(), pick_field(), hd);
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    logic nv;
    if (rst_ni && (!in_ch.valid || in_ch.ready)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!pause_sender && sample_queue.size() > 0) begin
        in_ch.data <= sample_queue.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      in_ch.valid <= nv;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((stall_left % 7) < 4);
      endcase
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    mbd_pkg::out_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        duty_queue.push_back(coil_drive(in_ch.data));
        idle_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (duty_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: expected none actual %h",
                   $time, out_ch.data);
        end else begin
          want = duty_queue.pop_front();
          if (out_ch.data !== want) begin
            errors++;
            $display({"%0t: mismatch expected dir_x=%0d pwm_x=%0d dir_y=%0d pwm_y=%0d ",
                      "law=%0d actual dir_x=%0d pwm_x=%0d dir_y=%0d pwm_y=%0d law=%0d"},
                     $time, want.dir_x, want.pwm_x, want.dir_y, want.pwm_y, want.law_used,
                     out_ch.data.dir_x, out_ch.data.pwm_x, out_ch.data.dir_y,
                     out_ch.data.pwm_y, out_ch.data.law_used);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    drive_cfg = '0;
    drive_cfg.vmax = 16'd1;
    build_sine_lut();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults
    repeat (40) push_random();
    wait_idle();

    // directed samples, then random ones
    write_all(16'h0100, 16'h0080, 16'h0200, 16'h0100, 16'h0400, 16'h4000, 16'd1000);
    write_reg(REG_UNUSED, 16'hFFFF);
    push_sample(1'b0, 0, 1000, -1000, 0);
    push_sample(1'b0, 255, 32767, 32767, 0);
    push_sample(1'b0, 32767, 32767, -32768, 0);
    push_sample(1'b0, -32768, -32768, 32767, 65535);
    push_sample(1'b0, 256, 0, 0, 0);
    push_sample(1'b0, -256, 100, 200, 0);
    push_sample(1'b1, 1024, 500, 500, 0);
    push_sample(1'b1, -1023, 500, -500, 0);
    push_sample(1'b1, 10, 3000, -3000, 16'h0000);
    push_sample(1'b1, 10, 3000, -3000, 16'h4000);
    push_sample(1'b1, 10, 3000, -3000, 16'h8000);
    push_sample(1'b1, 10, 3000, -3000, 16'hC000);
    push_sample(1'b1, 0, 3000, 3000, 16'h2000);
    push_sample(1'b1, 0, -32768, 32767, 16'hFFFF);
    push_sample(1'b1, -5, 32767, -32768, 16'h6000);
    push_sample(1'b1, 0, 0, 0, 16'hA000);
    for (int i = 0; i < 190; i++) push_random();
    wait_idle();

    // all maximum
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 95; i++) push_random();
    do @(negedge clk_i);
    while (sample_queue.size() != 0);
    pause_sender = 1'b1;
    do @(negedge clk_i);
    while (in_ch.valid || duty_queue.size() != 0);
    pause_sender = 1'b0;
    for (int i = 0; i < 95; i++) push_random();
    wait_idle();

    // zero gains, zero limit
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 150; i++) push_random();
    wait_idle();

    // tiny voltages against a large limit
    write_all(16'h0001, 16'h0003, 16'h0005, 16'hFFFF, 16'h0010, 16'h8000, 16'hFFFF);
    push_sample(1'b0, -32768, 1, 0, 0);
    push_sample(1'b0, 32767, 0, 1, 0);
    for (int i = 0; i < 180; i++) push_random();
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4096)),
                16'($urandom_range(0, 8192)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(1, 2000)));
      for (int i = 0; i < 130; i++) push_random();
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: magnetorquer_bdot_pwm_drive.f
+incdir+hdl
hdl/mbd_pkg.sv
hdl/mbd_stream_if.sv
hdl/mbd_law.sv
hdl/mbd_div.sv
hdl/magnetorquer_bdot_pwm_drive.sv
test/testbench.sv
